// ----- src/cpv_pkg.sv -----
// ----------------------------------------------------------------------------
// cpv_pkg
// Shared types and constants for the vectoring CORDIC phase pipeline.
// ----------------------------------------------------------------------------
package cpv_pkg;

    localparam int IN_W  = 31;
    localparam int OUT_W = 14;
    localparam int XW    = 34;
    localparam int ACC_W = 17;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 14'sd8191;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -14'sd8192;

    localparam real INV_PI = 0.31830988618379067154;

    typedef struct packed {
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ACC_W-1:0] acc;
    } vec_t;

    function automatic logic signed [ACC_W-1:0] step_angle(input int bits, input int k);
        real m;
        real a;
        m = (2.0 ** bits) - 1.0;
        if (k == 0)
        begin
            return ACC_W'((1 << (bits - 2)) - 1);
        end
        a = m * $atan(2.0 ** (-k)) * INV_PI;
        return ACC_W'($rtoi(a));
    endfunction

endpackage

// ----- src/cordic_phase_vectoring.sv -----
// ----------------------------------------------------------------------------
// cordic_phase_vectoring
// Phase of a signed I/Q pair, atan2(Q, I), in units of pi/(2^ANGLE_BITS-1).
// ----------------------------------------------------------------------------
// One beat in and one beat out per clock when the output side keeps up.
// A beat accepted at the input reaches a valid result at the output
// through ANGLE_BITS + 1 registers: a quarter-turn pre-rotation register,
// ANGLE_BITS - 1 unrolled shift-add micro-rotation stages, and an output
// register that negates and saturates the angle. Each stage advances when it
// is empty or the stage after it advances, so a stalled result holds the
// pipeline without dropping or repeating a beat.
module cordic_phase_vectoring #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [cpv_pkg::IN_W-1:0]     in_phase,
    input  logic signed [cpv_pkg::IN_W-1:0]     quadrature,
    output logic                                phase_valid,
    input  logic                                phase_ready,
    output logic signed [cpv_pkg::OUT_W-1:0]    phase_angle
);
    import cpv_pkg::*;

    localparam int NITER = ANGLE_BITS - 1;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'((1 << (ANGLE_BITS - 1)) - 1);

    vec_t                    vec_s [0:NITER];
    logic                    vld_s [0:NITER];
    logic                    adv   [0:NITER];
    logic                    adv_out;

    logic signed [XW-1:0]    i_ext;
    logic signed [XW-1:0]    q_ext;
    vec_t                    pre_next;
    vec_t                    pre_reg;
    logic                    pre_vld_reg;

    logic signed [ACC_W-1:0] neg_acc;
    logic signed [OUT_W-1:0] phase_next;
    logic signed [OUT_W-1:0] phase_reg;
    logic                    phase_vld_reg;

    assign adv_out = !phase_vld_reg || phase_ready;
    assign adv[NITER] = !vld_s[NITER] || adv_out;

    for (genvar s = 0; s < NITER; s++)
    begin : g_adv
        assign adv[s] = !vld_s[s] || adv[s+1];
    end

    assign sample_ready = adv[0];

    always_comb
    begin
        i_ext = XW'(in_phase);
        q_ext = XW'(quadrature);
        pre_next.x   = i_ext;
        pre_next.y   = q_ext;
        pre_next.acc = '0;
        if (i_ext[XW-1])
        begin
            if (!q_ext[XW-1] && (q_ext != '0))
            begin
                pre_next.x   = q_ext;
                pre_next.y   = -i_ext;
                pre_next.acc = -HALF;
            end
            else
            begin
                pre_next.x   = -q_ext;
                pre_next.y   = i_ext;
                pre_next.acc = HALF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
        end
        else if (adv[0])
        begin
            pre_vld_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pre_reg <= pre_next;
        end
    end

    assign vld_s[0] = pre_vld_reg;
    assign vec_s[0] = pre_reg;

    for (genvar k = 0; k < NITER; k++)
    begin : g_stage
        cpv_stage #(
            .SHIFT (k),
            .ANGLE (step_angle(ANGLE_BITS, k))
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv[k+1]),
            .vld_in  (vld_s[k]),
            .vec_in  (vec_s[k]),
            .vld_out (vld_s[k+1]),
            .vec_out (vec_s[k+1])
        );
    end

    always_comb
    begin
        neg_acc = -vec_s[NITER].acc;
        if (neg_acc > ACC_W'(OUT_MAX))
        begin
            phase_next = OUT_MAX;
        end
        else if (neg_acc < ACC_W'(OUT_MIN))
        begin
            phase_next = OUT_MIN;
        end
        else
        begin
            phase_next = neg_acc[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            phase_vld_reg <= vld_s[NITER];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            phase_reg <= phase_next;
        end
    end

    assign phase_valid = phase_vld_reg;
    assign phase_angle = phase_reg;

endmodule

// ----- src/cpv_stage.sv -----
// ----------------------------------------------------------------------------
// cpv_stage
// One registered vectoring micro-rotation, steered by the sign of y.
// ----------------------------------------------------------------------------
module cpv_stage #(
    parameter int                          SHIFT = 0,
    parameter logic signed [cpv_pkg::ACC_W-1:0] ANGLE = '0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  cpv_pkg::vec_t vec_in,
    output logic          vld_out,
    output cpv_pkg::vec_t vec_out
);
    import cpv_pkg::*;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    vec_t                 vec_next;
    vec_t                 vec_reg;
    logic                 vld_reg;

    always_comb
    begin
        xs = vec_in.x >>> SHIFT;
        ys = vec_in.y >>> SHIFT;
        if (!vec_in.y[XW-1])
        begin
            vec_next.x   = vec_in.x + ys;
            vec_next.y   = vec_in.y - xs;
            vec_next.acc = vec_in.acc - ANGLE;
        end
        else
        begin
            vec_next.x   = vec_in.x - ys;
            vec_next.y   = vec_in.y + xs;
            vec_next.acc = vec_in.acc + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vld_out = vld_reg;
    assign vec_out = vec_reg;

endmodule

// ----- src/cpv_checker.sv -----
// ----------------------------------------------------------------------------
// cpv_checker
// Port-level checks for the vectoring CORDIC phase pipeline.
// ----------------------------------------------------------------------------
module cpv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             sample_valid,
    input logic                             sample_ready,
    input logic signed [cpv_pkg::IN_W-1:0]  in_phase,
    input logic signed [cpv_pkg::IN_W-1:0]  quadrature,
    input logic                             phase_valid,
    input logic                             phase_ready,
    input logic signed [cpv_pkg::OUT_W-1:0] phase_angle
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=>
            sample_valid && $stable(in_phase) && $stable(quadrature))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        phase_valid && !phase_ready |=> phase_valid && $stable(phase_angle))
        else $error("result beat changed while stalled");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        phase_ready |-> sample_ready)
        else $error("pipeline blocked while output drains");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_valid |-> sample_ready)
        else $error("pipeline blocked with empty output register");

endmodule

bind cordic_phase_vectoring cpv_checker u_cpv_checker (.*);
